>>> rtl/sfcd_pkg.sv
// Shared types and constants for the SBUS frame channel decoder.
package sfcd_pkg;

    localparam int BYTE_W        = 8;
    localparam int CHAN_W        = 11;
    localparam int CHANNELS      = 16;
    localparam int CHAN_IDX_W    = 4;
    localparam int PAYLOAD_BYTES = 22;
    localparam int PAYLOAD_W     = PAYLOAD_BYTES * BYTE_W;
    localparam int FRAME_BYTES   = 25;
    localparam int POS_W         = 5;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [BYTE_W-1:0]     SYNC_BYTE = 8'h0F;
    localparam logic [CHAN_IDX_W-1:0] LAST_CHAN = CHAN_IDX_W'(CHANNELS - 1);

    // Command kinds passed from the front to the back.
    typedef enum logic {
        OP_STORE,
        OP_CLOSE
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] data;
    } t_cmd;

    // One command offered to, or presented by, the queue.
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_word;

endpackage

>>> rtl/sfcd_front.sv
// Front end: frame synchronisation and byte classification.
module sfcd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [sfcd_pkg::BYTE_W-1:0]   i_rx_byte,
    input  logic                          i_queue_full,
    output logic                          o_in_stall,
    output sfcd_pkg::t_cmd_word           o_push
);

    localparam logic [sfcd_pkg::POS_W-1:0] LAST_STORE_POS =
        sfcd_pkg::POS_W'(sfcd_pkg::PAYLOAD_BYTES);
    localparam logic [sfcd_pkg::POS_W-1:0] CLOSE_POS =
        sfcd_pkg::POS_W'(sfcd_pkg::FRAME_BYTES - 1);

    logic [sfcd_pkg::POS_W-1:0] r_pos;
    logic [sfcd_pkg::POS_W-1:0] n_pos;
    logic                       w_accept;

    // A word is only taken when the queue has room for whatever it may push.
    assign o_in_stall = i_queue_full;
    assign w_accept   = i_in_valid && !i_queue_full;

    // Classify the word by its place in the frame.
    always_comb begin
        n_pos            = r_pos;
        o_push.valid     = 1'b0;
        o_push.cmd.op    = sfcd_pkg::OP_STORE;
        o_push.cmd.data  = i_rx_byte;
        if (w_accept) begin
            if (r_pos == '0) begin
                if (i_rx_byte == sfcd_pkg::SYNC_BYTE) begin
                    n_pos = sfcd_pkg::POS_W'(1);
                end
            end else if (r_pos <= LAST_STORE_POS) begin
                o_push.valid = 1'b1;
                n_pos        = r_pos + sfcd_pkg::POS_W'(1);
            end else if (r_pos < CLOSE_POS) begin
                // Flag byte: counted, not kept.
                n_pos = r_pos + sfcd_pkg::POS_W'(1);
            end else if (r_pos == CLOSE_POS) begin
                // End byte closes the frame whatever its value.
                o_push.valid  = 1'b1;
                o_push.cmd.op = sfcd_pkg::OP_CLOSE;
                n_pos         = '0;
            end else begin
                n_pos = '0;
            end
        end
    end

    // Frame position register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= CLOSE_POS)
        else $error("frame position left the frame");

endmodule

>>> rtl/sfcd_queue.sv
// Short command queue between the front and the back.
module sfcd_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sfcd_pkg::t_cmd_word  i_push,
    output logic                 o_full,
    output sfcd_pkg::t_cmd_word  o_head,
    input  logic                 i_pop_ready
);

    localparam logic [sfcd_pkg::QPTR_W-1:0] LAST_SLOT =
        sfcd_pkg::QPTR_W'(sfcd_pkg::QUEUE_DEPTH - 1);
    localparam logic [sfcd_pkg::QCNT_W-1:0] FULL_COUNT =
        sfcd_pkg::QCNT_W'(sfcd_pkg::QUEUE_DEPTH);

    sfcd_pkg::t_cmd                r_mem [sfcd_pkg::QUEUE_DEPTH];
    logic [sfcd_pkg::QPTR_W-1:0]   r_wr;
    logic [sfcd_pkg::QPTR_W-1:0]   r_rd;
    logic [sfcd_pkg::QCNT_W-1:0]   r_count;
    logic                          w_push;
    logic                          w_pop;

    assign o_full       = (r_count == FULL_COUNT);
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rd];
    assign w_push       = i_push.valid && !o_full;
    assign w_pop        = o_head.valid && i_pop_ready;

    // Storage for queued commands.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push.cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == LAST_SLOT) ? '0 : r_wr + sfcd_pkg::QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == LAST_SLOT) ? '0 : r_rd + sfcd_pkg::QPTR_W'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + sfcd_pkg::QCNT_W'(1);
                2'b01:   r_count <= r_count - sfcd_pkg::QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push.valid)
        else $error("command pushed into a full queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("queue count overflow");

endmodule

>>> rtl/sfcd_back.sv
// Back end: payload collection and channel unpacking with output register.
module sfcd_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sfcd_pkg::t_cmd_word               i_head,
    output logic                              o_pop_ready,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [sfcd_pkg::CHAN_IDX_W-1:0]   o_channel_index,
    output logic [sfcd_pkg::CHAN_W-1:0]       o_channel_value,
    output logic                              o_last_channel
);

    typedef enum logic {
        ST_COLLECT,
        ST_UNPACK
    } t_state;

    t_state                            r_state;
    logic [sfcd_pkg::PAYLOAD_W-1:0]    r_payload;
    logic [sfcd_pkg::CHAN_IDX_W-1:0]   r_chan;
    logic                              r_out_valid;
    logic [sfcd_pkg::CHAN_IDX_W-1:0]   r_out_index;
    logic [sfcd_pkg::CHAN_W-1:0]       r_out_value;
    logic                              r_out_last;
    logic                              w_out_free;

    assign o_pop_ready     = (r_state == ST_COLLECT);
    assign o_out_valid     = r_out_valid;
    assign o_channel_index = r_out_index;
    assign o_channel_value = r_out_value;
    assign o_last_channel  = r_out_last;
    assign w_out_free      = !r_out_valid || !i_out_stall;

    // Payload bytes shift in from the top; channels leave from the bottom.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_COLLECT;
            r_chan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_COLLECT: begin
                    // A word taken by the receiver leaves the output register.
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                    end
                    if (i_head.valid) begin
                        if (i_head.cmd.op == sfcd_pkg::OP_STORE) begin
                            r_payload <= {i_head.cmd.data,
                                          r_payload[sfcd_pkg::PAYLOAD_W-1:sfcd_pkg::BYTE_W]};
                        end else begin
                            r_chan  <= '0;
                            r_state <= ST_UNPACK;
                        end
                    end
                end
                ST_UNPACK: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_index <= r_chan;
                        r_out_value <= r_payload[sfcd_pkg::CHAN_W-1:0];
                        r_out_last  <= (r_chan == sfcd_pkg::LAST_CHAN);
                        r_payload   <= r_payload >> sfcd_pkg::CHAN_W;
                        r_chan      <= r_chan + sfcd_pkg::CHAN_IDX_W'(1);
                        if (r_chan == sfcd_pkg::LAST_CHAN) begin
                            r_state <= ST_COLLECT;
                        end
                    end
                end
                default: begin
                    r_state <= ST_COLLECT;
                end
            endcase
        end
    end

    a_last_is_fifteen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (r_out_index == sfcd_pkg::LAST_CHAN))
        else $error("last channel flag on wrong index");

    a_stalled_word_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out_value)
                                          && $stable(r_out_index)))
        else $error("stalled output word changed");

    a_run_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UNPACK && w_out_free && r_chan != '0)
            |-> (r_out_index == r_chan - sfcd_pkg::CHAN_IDX_W'(1)))
        else $error("channel run out of order");

endmodule

>>> rtl/sbus_frame_channel_decoder_core.sv
// Top level of the SBUS sixteen-channel frame decoder.
//
// Input channel: one received byte per word on i_rx_byte, offered with
// i_in_valid and held off by o_in_stall. Bytes are dropped until the start
// byte 0x0F; the next 24 bytes form the frame, and the 24th closes it.
// Output channel: one channel value per word (o_channel_index,
// o_channel_value, o_last_channel), offered with o_out_valid and held
// off by i_out_stall. Each closed frame gives sixteen words, channel 0
// first, with o_last_channel set on channel 15.
// Throughput: one input byte per cycle while o_in_stall is low; a closing
// byte keeps the back end busy while it emits one channel per cycle, while
// i_out_stall is low, from a shift register over the 176-bit payload. A
// two-entry command queue sits between the byte classifier and the back end.
// A closing byte passes through the queue and turns the back end to
// unpacking; each channel word then leaves through the output register.
// Reset clears the frame position, the queue and the output register; the
// payload register needs no clearing since each frame rewrites it fully.
// When the receiver stalls, the output word holds, the back end pauses,
// the queue fills and o_in_stall then rises.
module sbus_frame_channel_decoder_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [sfcd_pkg::BYTE_W-1:0]       i_rx_byte,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [sfcd_pkg::CHAN_IDX_W-1:0]   o_channel_index,
    output logic [sfcd_pkg::CHAN_W-1:0]       o_channel_value,
    output logic                              o_last_channel
);

    sfcd_pkg::t_cmd_word w_push;
    sfcd_pkg::t_cmd_word w_head;
    logic                w_queue_full;
    logic                w_pop_ready;

    // Byte classification.
    sfcd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_rx_byte    (i_rx_byte),
        .i_queue_full (w_queue_full),
        .o_in_stall   (o_in_stall),
        .o_push       (w_push)
    );

    // Decoupling queue.
    sfcd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .o_full      (w_queue_full),
        .o_head      (w_head),
        .i_pop_ready (w_pop_ready)
    );

    // Payload collection and unpacking.
    sfcd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (w_head),
        .o_pop_ready     (w_pop_ready),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_channel_index (o_channel_index),
        .o_channel_value (o_channel_value),
        .o_last_channel  (o_last_channel)
    );

endmodule

>>> tb/sv/sbus_channel_board_pkg.sv
`timescale 1ns / 1ps
// Scoreboard class that predicts and checks the channel words of the SBUS frame decoder.
package sbus_channel_board_pkg;

    // One channel word as it leaves the decoder.
    typedef struct packed {
        logic [sfcd_pkg::CHAN_IDX_W-1:0] index;
        logic [sfcd_pkg::CHAN_W-1:0]     value;
        logic                            last;
    } t_chan_word;

    class sbus_channel_board;
        logic [sfcd_pkg::POS_W-1:0]  frame_pos;
        logic [sfcd_pkg::BYTE_W-1:0] payload [sfcd_pkg::PAYLOAD_BYTES];
        t_chan_word                  pending_words [$];
        int unsigned                 mismatches;
        int unsigned                 frames_closed;
        int unsigned                 words_checked;

        function new();
            frame_pos     = '0;
            foreach (payload[i]) payload[i] = '0;
            mismatches    = 0;
            frames_closed = 0;
            words_checked = 0;
        endfunction

        // Advances the frame tracker by one accepted byte and, on the closing byte,
        // queues the sixteen channel words that the frame unpacks to.
        function void note_byte(logic [sfcd_pkg::BYTE_W-1:0] rx);
            logic [sfcd_pkg::PAYLOAD_W-1:0] stream;
            t_chan_word                     w;
            int unsigned                    pos;
            int unsigned                    i;
            int unsigned                    k;
            pos = frame_pos;
            if (pos == 0) begin
                if (rx == sfcd_pkg::SYNC_BYTE) frame_pos = sfcd_pkg::POS_W'(1);
                return;
            end
            // Flag and end bytes are counted but not stored.
            if (pos <= sfcd_pkg::PAYLOAD_BYTES) payload[pos-1] = rx;
            if (pos >= sfcd_pkg::FRAME_BYTES) begin
                frame_pos = '0;
                return;
            end
            pos++;
            if (pos < sfcd_pkg::FRAME_BYTES) begin
                frame_pos = sfcd_pkg::POS_W'(pos);
                return;
            end
            frame_pos = '0;
            frames_closed++;
            // The payload is one stream, least significant bit first.
            for (i = 0; i < sfcd_pkg::PAYLOAD_BYTES; i++) begin
                stream[i*sfcd_pkg::BYTE_W +: sfcd_pkg::BYTE_W] = payload[i];
            end
            for (k = 0; k < sfcd_pkg::CHANNELS; k++) begin
                w.index = sfcd_pkg::CHAN_IDX_W'(k);
                w.value = stream[k*sfcd_pkg::CHAN_W +: sfcd_pkg::CHAN_W];
                w.last  = (w.index == sfcd_pkg::LAST_CHAN);
                pending_words.push_back(w);
            end
        endfunction

        // Compares one accepted channel word with the oldest prediction.
        function void check_word(logic [sfcd_pkg::CHAN_IDX_W-1:0] index,
                                 logic [sfcd_pkg::CHAN_W-1:0]     value,
                                 logic                            last);
            t_chan_word want;
            if (pending_words.size() == 0) begin
                $error({"Unexpected channel word: channel_index %0d channel_value %0d ",
                        "last_channel %0d"}, index, value, last);
                mismatches++;
                return;
            end
            want = pending_words.pop_front();
            words_checked++;
            if (index !== want.index) begin
                $error("channel_index mismatch: expected %0d, actual %0d", want.index, index);
                mismatches++;
            end
            if (value !== want.value) begin
                $error("channel_value mismatch: expected %0d, actual %0d", want.value, value);
                mismatches++;
            end
            if (last !== want.last) begin
                $error("last_channel mismatch: expected %0d, actual %0d", want.last, last);
                mismatches++;
            end
        endfunction

        function int unsigned outstanding();
            return pending_words.size();
        endfunction
    endclass

endpackage

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top-level testbench for the SBUS frame channel decoder core.
module testbench;

    localparam int          STALL_LIMIT  = 4000;
    localparam int          PHASE_BYTES  = 106;
    localparam int          SETTLE_WAIT  = 12;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_stall;
    logic [sfcd_pkg::BYTE_W-1:0]     i_rx_byte;
    logic                            o_out_valid;
    logic                            i_out_stall;
    logic [sfcd_pkg::CHAN_IDX_W-1:0] o_channel_index;
    logic [sfcd_pkg::CHAN_W-1:0]     o_channel_value;
    logic                            o_last_channel;

    sbus_channel_board_pkg::sbus_channel_board board;
    int unsigned       send_idle_pct;
    int unsigned       recv_stall_pct;
    int unsigned       bytes_sent;
    int unsigned       directed_bytes;
    int unsigned       idle_run;

    sbus_frame_channel_decoder_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_channel_index (o_channel_index),
        .o_channel_value (o_channel_value),
        .o_last_channel  (o_last_channel)
    );

    // Free-running clock.
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // The receiver stalls at random according to the current phase.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Every accepted channel word is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            board.check_word(o_channel_index, o_channel_value, o_last_channel);
        end
    end

    // Watchdog: ends the run when neither side moves a word for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_run <= 0;
        end else if (idle_run >= STALL_LIMIT) begin
            $display("Timeout: no word accepted for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

    // Offers one byte, with random idle cycles ahead of it, and waits for acceptance.
    // Valid stays high afterwards so that back-to-back bytes need no second update.
    task automatic send_byte(input logic [sfcd_pkg::BYTE_W-1:0] rx);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= rx;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_byte(rx);
        bytes_sent++;
    endtask

    // Holds the sender off until every predicted channel word has arrived.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.outstanding() != 0) @(posedge i_clk);
    endtask

    // A frame with random content, sometimes preceded by stray bytes; a stray
    // start byte opens a frame early and so shifts the rest out of line.
    task automatic send_random_frame();
        int unsigned                 noise;
        int unsigned                 n;
        int unsigned                 style;
        logic [sfcd_pkg::BYTE_W-1:0] rx;
        noise = ($urandom_range(0, 9) < 3) ? $urandom_range(1, 3) : 0;
        for (n = 0; n < noise; n++) send_byte(sfcd_pkg::BYTE_W'($urandom_range(0, 255)));
        send_byte(sfcd_pkg::SYNC_BYTE);
        style = $urandom_range(0, 3);
        for (n = 1; n < sfcd_pkg::FRAME_BYTES; n++) begin
            rx = sfcd_pkg::BYTE_W'($urandom_range(0, 255));
            // Some frames lean on the extreme and start-byte values.
            if (style == 0) begin
                case ($urandom_range(0, 3))
                    0: rx = 8'h00;
                    1: rx = 8'hFF;
                    2: rx = sfcd_pkg::SYNC_BYTE;
                    default: ;
                endcase
            end
            send_byte(rx);
        end
    endtask

    // Main sequence.
    initial begin
        int unsigned phase;
        int unsigned goal;
        int unsigned n;
        board          = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        bytes_sent     = 0;
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_rx_byte      <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: bytes dropped before sync, then one frame whose first eleven payload
        // bytes are all ones and the rest all zeros, with a start byte as the flag byte
        // and an arbitrary end byte.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hF0);
        send_byte(8'h0E);
        send_byte(sfcd_pkg::SYNC_BYTE);
        for (n = 0; n < sfcd_pkg::PAYLOAD_BYTES; n++) send_byte((n < 11) ? 8'hFF : 8'h00);
        send_byte(sfcd_pkg::SYNC_BYTE);
        send_byte(8'hA5);
        directed_bytes = bytes_sent;
        drain_results();

        // Random frames across the idling phases.
        goal = bytes_sent;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            goal += PHASE_BYTES;
            while (bytes_sent < goal) send_random_frame();
            drain_results();
        end

        // Let any trailing activity settle before the verdict.
        repeat (SETTLE_WAIT) @(posedge i_clk);
        if (board.outstanding() != 0) begin
            $error("%0d predicted channel words never arrived", board.outstanding());
            board.mismatches++;
        end
        $display("Summary: %0d bytes sent (%0d directed), %0d frames closed.",
                 bytes_sent, directed_bytes, board.frames_closed);
        $display("Checked %0d channel words with no idling, sender idle, receiver stalling and both.",
                 board.words_checked);
        if (board.mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
